[sv/sfla_pkg.sv]
// Shared types, constants and index helpers for the sub-pool block allocator.
package sfla_pkg;

	localparam int NUM_SUBPOOLS    = 4;
	localparam int BLOCKS_PER_POOL = 64;

	localparam int IDX_W     = 8;
	localparam int COUNT_W   = 7;
	localparam int LINK_W    = 7;
	localparam int STATUS_W  = 2;
	localparam int NUM_ENTRIES = 1 << IDX_W;

	localparam int MAX_POOLS_FIT = NUM_ENTRIES / BLOCKS_PER_POOL;
	localparam int USABLE_POOLS  = (NUM_SUBPOOLS < MAX_POOLS_FIT) ? NUM_SUBPOOLS : MAX_POOLS_FIT;
	localparam int POOL_W        = (USABLE_POOLS > 1) ? $clog2(USABLE_POOLS) : 1;
	localparam int TOTAL_BLOCKS  = USABLE_POOLS * BLOCKS_PER_POOL;

	localparam int IN_DATA_W  = ((COUNT_W + IDX_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((IDX_W + 7) / 8) * 8;

	// End-of-list marker stored in links and list heads.
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(64);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_NOT_OCC  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_FREE,
		S_NOSPACE,
		S_BADFREE
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic pop;
		logic free_upd;
		logic err_nospace;
		logic err_badfree;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_free;
		logic in_count_zero;
		logic in_pool_found;
		logic in_free_ok;
		logic head_null;
		logic pop_last;
		logic slot_free;
	} dp_stat_t;

	function automatic logic [POOL_W-1:0] pool_of(input logic [IDX_W-1:0] idx);
		logic [POOL_W-1:0] r;
		r = '0;
		for (int p = 1; p < USABLE_POOLS; p++) begin
			if (int'(idx) >= p * BLOCKS_PER_POOL) begin
				r = POOL_W'(p);
			end
		end
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] pool_base(input logic [POOL_W-1:0] pool);
		return IDX_W'(int'(pool) * BLOCKS_PER_POOL);
	endfunction

	function automatic logic [LINK_W-1:0] local_of(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] d;
		d = idx - pool_base(pool_of(idx));
		return d[LINK_W-1:0];
	endfunction

	// Link held by an entry that was never written since reset.
	function automatic logic [LINK_W-1:0] default_link(input logic [IDX_W-1:0] idx);
		logic [LINK_W-1:0] l;
		l = local_of(idx);
		return (int'(l) + 1 < BLOCKS_PER_POOL) ? LINK_W'(int'(l) + 1) : LINK_NULL;
	endfunction

endpackage

[sv/sfla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/sfla_ctrl.sv]
// Controller state machine that sequences accepts, pops, frees and error results.
module sfla_ctrl import sfla_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (stat.in_is_free) begin
						state_d = stat.in_free_ok ? S_FREE : S_BADFREE;
					end else if (stat.in_count_zero) begin
						state_d = S_IDLE;
					end else begin
						state_d = stat.in_pool_found ? S_POP : S_NOSPACE;
					end
				end
			end
			S_POP: begin
				if (stat.slot_free && (stat.head_null || stat.pop_last)) begin
					state_d = S_IDLE;
				end
			end
			S_FREE, S_NOSPACE, S_BADFREE: begin
				if (stat.slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = accept;
			end
			S_POP: begin
				cmd.pop         = stat.slot_free && !stat.head_null;
				cmd.err_nospace = stat.slot_free && stat.head_null;
			end
			S_FREE:    cmd.free_upd    = stat.slot_free;
			S_NOSPACE: cmd.err_nospace = stat.slot_free;
			S_BADFREE: cmd.err_badfree = stat.slot_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	// A run of pops always ends back in idle, never in another work state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP && state_d != S_POP) |-> state_d == S_IDLE)
		else $error("pop run left to a state other than idle");

endmodule

[sv/sfla_dp.sv]
// Datapath: free-list heads, used counts, link RAM with occupied flags, result register.
module sfla_dp import sfla_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic               in_op,
	input  logic [COUNT_W-1:0] in_count,
	input  logic [IDX_W-1:0]   in_blk,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   out_blk,
	output status_t            out_status,
	output logic               out_last
);

	localparam logic [COUNT_W:0] BPP_X   = (COUNT_W + 1)'(BLOCKS_PER_POOL);
	localparam logic [LINK_W-1:0] BPP_L  = LINK_W'(BLOCKS_PER_POOL);
	localparam logic [IDX_W:0]   TOTAL_X = (IDX_W + 1)'(TOTAL_BLOCKS);

	logic [LINK_W-1:0]  free_head_q [USABLE_POOLS];
	logic [COUNT_W-1:0] used_q      [USABLE_POOLS];
	logic [NUM_ENTRIES-1:0] valid_q;

	logic [POOL_W-1:0]  pool_q;
	logic [COUNT_W-1:0] remain_q;
	logic [IDX_W-1:0]   blk_q;
	logic [IDX_W-1:0]   rd_addr_q;
	logic               rd_valid_q;

	logic               out_valid_q;
	logic [IDX_W-1:0]   out_blk_q;
	status_t            out_status_q;
	logic               out_last_q;

	logic [USABLE_POOLS-1:0] fits;
	logic               pool_found;
	logic [POOL_W-1:0]  pool_sel;

	logic [LINK_W:0]    ram_rdata;
	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr, rd_addr;
	logic [LINK_W:0]    ram_wdata;

	logic [LINK_W-1:0]  head_cur, entry_link;
	logic               entry_occ, pop_last, slot_free, emit;
	logic [IDX_W-1:0]   pop_g;

	// First-fit search over the sub-pools, lowest index wins.
	always_comb begin
		for (int p = 0; p < USABLE_POOLS; p++) begin
			fits[p] = ({1'b0, used_q[p]} <= BPP_X) &&
				((BPP_X - {1'b0, used_q[p]}) >= {1'b0, in_count});
		end
		pool_found = 1'b0;
		pool_sel   = '0;
		for (int p = USABLE_POOLS - 1; p >= 0; p--) begin
			if (fits[p]) begin
				pool_found = 1'b1;
				pool_sel   = POOL_W'(p);
			end
		end
	end

	assign head_cur   = free_head_q[pool_q];
	assign entry_occ  = rd_valid_q ? ram_rdata[LINK_W] : 1'b0;
	assign entry_link = rd_valid_q ? ram_rdata[LINK_W-1:0] : default_link(rd_addr_q);
	assign pop_g      = pool_base(pool_q) + IDX_W'(head_cur);
	assign pop_last   = (remain_q == COUNT_W'(1)) || (entry_link >= BPP_L);
	assign slot_free  = !out_valid_q || out_ready;
	assign emit       = cmd.pop || cmd.free_upd || cmd.err_nospace || cmd.err_badfree;

	always_comb begin
		if (cmd.load) begin
			rd_addr = (in_op == OP_FREE) ? in_blk :
				pool_base(pool_sel) + IDX_W'(free_head_q[pool_sel]);
		end else begin
			rd_addr = pool_base(pool_q) + IDX_W'(entry_link);
		end
	end

	assign ram_re    = cmd.load || (cmd.pop && !pop_last);
	assign ram_we    = cmd.pop || (cmd.free_upd && entry_occ);
	assign ram_waddr = cmd.pop ? pop_g : blk_q;
	assign ram_wdata = cmd.pop ? {1'b1, entry_link} : {1'b0, head_cur};

	sfla_ram #(
		.WIDTH(LINK_W + 1),
		.DEPTH(NUM_ENTRIES)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < USABLE_POOLS; p++) begin
				free_head_q[p] <= '0;
				used_q[p]      <= '0;
			end
			valid_q     <= '0;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_re) begin
				rd_valid_q <= valid_q[rd_addr];
			end
			if (cmd.pop) begin
				free_head_q[pool_q] <= entry_link;
				used_q[pool_q]      <= used_q[pool_q] + COUNT_W'(1);
				valid_q[pop_g]      <= 1'b1;
			end
			if (cmd.free_upd && entry_occ) begin
				free_head_q[pool_q] <= local_of(blk_q);
				if (used_q[pool_q] != '0) begin
					used_q[pool_q] <= used_q[pool_q] - COUNT_W'(1);
				end
				valid_q[blk_q] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pool_q   <= (in_op == OP_FREE) ? pool_of(in_blk) : pool_sel;
			remain_q <= in_count;
			blk_q    <= in_blk;
		end else if (cmd.pop) begin
			remain_q <= remain_q - COUNT_W'(1);
		end
		if (ram_re) begin
			rd_addr_q <= rd_addr;
		end
		if (emit) begin
			if (cmd.pop) begin
				out_blk_q    <= pop_g;
				out_status_q <= ST_OK;
				out_last_q   <= pop_last;
			end else if (cmd.free_upd && entry_occ) begin
				out_blk_q    <= blk_q;
				out_status_q <= ST_OK;
				out_last_q   <= 1'b1;
			end else if (cmd.err_nospace) begin
				out_blk_q    <= '0;
				out_status_q <= ST_NO_SPACE;
				out_last_q   <= 1'b1;
			end else begin
				out_blk_q    <= '0;
				out_status_q <= ST_NOT_OCC;
				out_last_q   <= 1'b1;
			end
		end
	end

	assign stat.in_is_free    = (in_op == OP_FREE);
	assign stat.in_count_zero = (in_count == '0);
	assign stat.in_pool_found = pool_found;
	assign stat.in_free_ok    = ({1'b0, in_blk} < TOTAL_X);
	assign stat.head_null     = (head_cur >= BPP_L);
	assign stat.pop_last      = pop_last;
	assign stat.slot_free     = slot_free;

	assign out_valid  = out_valid_q;
	assign out_blk    = out_blk_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	// A block taken from a free list must not already be marked occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !entry_occ)
		else $error("popped block already occupied");

	// A new result never overwrites one the receiver has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && out_valid_q) |-> out_ready)
		else $error("result register overwritten");

	// Freeing an occupied block implies its sub-pool has a nonzero used count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.free_upd && entry_occ) |-> (used_q[pool_q] != '0))
		else $error("used count out of step with occupied flags");

endmodule

[sv/subpool_free_list_allocator_unit.sv]
// Top level of the sub-pool free-list block allocator.
//
// The pool of 256 blocks is split into equal sub-pools, each with a LIFO
// free list kept as one link per block in a block RAM plus a head register.
// Requests arrive on the s_axis channel: tuser selects allocate or free, and
// tdata carries the block count and the block index. Results leave on the
// m_axis channel, one transfer per allocated block, or a single transfer for
// a free or an error; tlast marks the final result of each request.
// An allocate first reads the head entry of the chosen sub-pool, then pops
// one block at a time, each pop following a link read from the registered
// RAM. A free reads the block's entry and occupied flag, then pushes it.
// An allocate with a zero count produces nothing.
// One request is in work at a time; the next is accepted once the last
// result of the current one is in the output register.
// Reset is immediate: a valid bit per RAM entry makes unwritten entries read
// as their initial link, so no clearing pass runs and the first request is
// accepted in the cycle after reset is released.
// When the receiver stalls, the output register holds its result and the
// pop sequence waits; nothing is dropped.
module subpool_free_list_allocator_unit import sfla_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // count [6:0], block_index [14:7], zero
	input  logic                  s_axis_tuser,   // op
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // block_index_res [7:0]
	output logic [STATUS_W-1:0]   m_axis_tuser,   // status [1:0]
	output logic                  m_axis_tlast    // last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic [IDX_W-1:0] out_blk;
	status_t          out_status;

	// The controller keeps only its sequencing state and decides what happens
	// each cycle; the free lists, used counts and results live in the datapath.
	sfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sfla_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (s_axis_tuser),
		.in_count   (s_axis_tdata[COUNT_W-1:0]),
		.in_blk     (s_axis_tdata[COUNT_W +: IDX_W]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_blk    (out_blk),
		.out_status (out_status),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_DATA_W'(out_blk);
	assign m_axis_tuser = out_status;

	// Every error result is a lone transfer with a zero block index.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != ST_OK)) |->
			(m_axis_tdata == '0) && m_axis_tlast)
		else $error("error result with nonzero index or without last");

endmodule
